[rtl/bfpc_pkg.sv]
// Shared types, constants and helper functions for the position controller.
`timescale 1ns / 1ps
package bfpc_pkg;

  // Field widths
  localparam int POS_W  = 32;
  localparam int Q_W    = 16;
  localparam int ANG_W  = 16;
  localparam int GAIN_W = 16;
  localparam int IN_W   = 176;
  localparam int OUT_W  = 128;

  // Serial multiplier: 64-bit multiplicand, 32-bit signed multiplier
  localparam int MUL_AW = 64;
  localparam int MUL_BW = 32;
  localparam int MUL_CW = 5;

  // CORDIC datapath widths; angles in units of 2^-30 rad
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CW     = 38;
  localparam int ZW     = 36;
  localparam int IDX_W  = 5;
  localparam int ATAN_LEN = 24;

  localparam logic signed [ZW-1:0] ANG_PI      = 36'sd3373259426;
  localparam logic signed [ZW-1:0] ANG_HALF_PI = 36'sd1686629713;
  localparam logic signed [CW-1:0] CORDIC_SCALE = 38'sd652032874;

  localparam logic [GAIN_W-1:0] GAIN_RST = 16'd819;

  // Register indexes
  localparam logic [1:0] REG_GAIN_XY      = 2'd0;
  localparam logic [1:0] REG_GAIN_Z       = 2'd1;
  localparam logic [1:0] REG_GAIN_HEADING = 2'd2;

  // Item kinds
  localparam logic ACT_ODOM   = 1'b0;
  localparam logic ACT_TARGET = 1'b1;

  typedef enum logic {CM_VEC, CM_ROT} cordic_mode_t;

  typedef struct packed {
    logic         start;
    cordic_mode_t mode;
  } cordic_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE, S_QMUL, S_VEC, S_GMUL, S_ROT, S_RMUL, S_EMIT
  } seq_state_t;

  // arctan(2^-i) in units of 2^-30 rad
  function automatic logic signed [ZW-1:0] atan_val(input logic [IDX_W-1:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:  v = 36'sd843314857;
      5'd1:  v = 36'sd497837829;
      5'd2:  v = 36'sd263043837;
      5'd3:  v = 36'sd133525158;
      5'd4:  v = 36'sd67021687;
      5'd5:  v = 36'sd33543516;
      5'd6:  v = 36'sd16775851;
      5'd7:  v = 36'sd8388437;
      5'd8:  v = 36'sd4194283;
      5'd9:  v = 36'sd2097149;
      5'd10: v = 36'sd1048576;
      5'd11: v = 36'sd524288;
      5'd12: v = 36'sd262144;
      5'd13: v = 36'sd131072;
      5'd14: v = 36'sd65536;
      5'd15: v = 36'sd32768;
      5'd16: v = 36'sd16384;
      5'd17: v = 36'sd8192;
      5'd18: v = 36'sd4096;
      5'd19: v = 36'sd2048;
      5'd20: v = 36'sd1024;
      5'd21: v = 36'sd512;
      5'd22: v = 36'sd256;
      5'd23: v = 36'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Clamp a 64-bit signed value to the signed 32-bit range
  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sd2147483647) r = 32'h7FFF_FFFF;
    else if (v < -64'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

[rtl/bfpc_mul.sv]
// Bit-serial signed multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module bfpc_mul
  import bfpc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [MUL_AW-1:0] a_i,
  input  logic signed [MUL_BW-1:0] b_i,
  output logic                     done,
  output logic signed [MUL_AW-1:0] p_o
);

  logic                     busy_r, done_r;
  logic [MUL_CW-1:0]        cnt_r;
  logic signed [MUL_AW-1:0] acc_r, a_r, acc_nxt, term;
  logic [MUL_BW-1:0]        b_r;
  logic                     last;

  assign last = (cnt_r == MUL_CW'(MUL_BW - 1));
  assign term = b_r[0] ? a_r : '0;
  // top multiplier bit has negative weight
  assign acc_nxt = last ? (acc_r - term) : (acc_r + term);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift registers and accumulator
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      a_r   <= a_i;
      b_r   <= b_i;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      a_r   <= a_r <<< 1;
      b_r   <= b_r >> 1;
    end
  end

  assign done = done_r;
  assign p_o  = acc_r;

endmodule

[rtl/bfpc_cordic.sv]
// Iterative CORDIC, vectoring (atan2) or rotation (cos/sin), one step per cycle.
`timescale 1ns / 1ps
module bfpc_cordic
  import bfpc_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cordic_ctl_t          ctl,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  output logic                 done,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o,
  output logic signed [ZW-1:0] z_o
);

  logic                 busy_r, done_r, neg_r;
  cordic_mode_t         mode_r;
  logic [IDX_W-1:0]     i_r;
  logic signed [CW-1:0] x_r, y_r, dx, dy;
  logic signed [ZW-1:0] z_r, at;
  logic                 last;

  assign last = (i_r == IDX_W'(CORDIC_STEPS - 1));
  assign dx   = y_r >>> i_r;
  assign dy   = x_r >>> i_r;
  assign at   = atan_val(i_r);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        i_r    <= '0;
      end else if (busy_r) begin
        i_r <= i_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: quadrant fold on start, then micro-rotations
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      mode_r <= ctl.mode;
      neg_r  <= 1'b0;
      x_r    <= x_i;
      y_r    <= y_i;
      z_r    <= z_i;
      if (ctl.mode == CM_VEC) begin
        if (x_i < 0) begin
          x_r <= -x_i;
          y_r <= -y_i;
          z_r <= (y_i >= 0) ? ANG_PI : -ANG_PI;
        end else begin
          z_r <= '0;
        end
      end else begin
        if (z_i > ANG_HALF_PI) begin
          z_r   <= z_i - ANG_PI;
          neg_r <= 1'b1;
        end else if (z_i < -ANG_HALF_PI) begin
          z_r   <= z_i + ANG_PI;
          neg_r <= 1'b1;
        end
      end
    end else if (busy_r) begin
      if (mode_r == CM_VEC) begin
        if (y_r >= 0) begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + at;
        end else begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - at;
        end
      end else begin
        if (z_r >= 0) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + at;
        end
      end
    end
  end

  assign done = done_r;
  assign x_o  = neg_r ? -x_r : x_r;
  assign y_o  = neg_r ? -y_r : y_r;
  assign z_o  = z_r;

endmodule

[rtl/body_frame_position_p_controller_top.sv]
// Body-frame proportional position controller: sequencer, state and ports.
// Odometry transaction: 4 serial products, then a vectoring CORDIC for the heading
// (skipped for a zero vector); no result. Target transaction: 8 serial products
// around a rotation CORDIC, ending in a valid result. One item at a time; the serial
// multiplier works one bit per cycle. A stalled result holds the next target in S_EMIT.
// Reset (rst_n, synchronous): gains to 819, stored position and heading to 0.
`timescale 1ns / 1ps
module body_frame_position_p_controller_top
  import bfpc_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z, target_heading
  input  logic [IN_W-1:0]   in_tdata,
  // action
  input  logic              in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  // vel_x, vel_y, vel_z, heading_rate
  output logic [OUT_W-1:0]  out_tdata,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [GAIN_W-1:0] cfg_wdata
);

  seq_state_t state_r, state_nxt;
  logic [1:0] mi_r;
  logic       issue_r;

  logic [GAIN_W-1:0]        gxy_r, gz_r, gh_r;
  logic signed [POS_W-1:0]  cur_x_r, cur_y_r, cur_z_r, px_r, py_r, pz_r;
  logic signed [ANG_W-1:0]  cur_h_r, th_r;
  logic signed [Q_W-1:0]    qw_r, qx_r, qy_r, qz_r;
  logic signed [63:0]       acc_r, vx_r, vy_r;
  logic signed [CW-1:0]     t1_r, t0_r;
  logic [31:0]              ox_r, oy_r, oz_r, oh_r;
  logic signed [31:0]       c_r, s_r;
  logic                     out_valid_r;
  logic [OUT_W-1:0]         out_data_r;

  logic                     accept, mul_start, mul_done, cor_done, last_mul, vec_zero;
  logic signed [MUL_AW-1:0] mul_a, mul_p;
  logic signed [MUL_BW-1:0] mul_b;
  cordic_ctl_t              cor_ctl;
  logic signed [CW-1:0]     cor_x0, cor_y0, cor_xo, cor_yo;
  logic signed [ZW-1:0]     cor_z0, cor_zo;
  logic signed [63:0]       sum, heading_w, cos_w, sin_w;

  assign accept   = in_tvalid && in_tready;
  assign last_mul = (mi_r == 2'd3);
  assign vec_zero = (t1_r == '0) && (t0_r == '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) state_nxt = (in_tuser == ACT_TARGET) ? S_GMUL : S_QMUL;
      S_QMUL: if (mul_done && last_mul) state_nxt = S_VEC;
      S_VEC:  if ((issue_r && vec_zero) || cor_done) state_nxt = S_IDLE;
      S_GMUL: if (mul_done && last_mul) state_nxt = S_ROT;
      S_ROT:  if (cor_done) state_nxt = S_RMUL;
      S_RMUL: if (mul_done && last_mul) state_nxt = S_EMIT;
      S_EMIT: if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs and operand selection
  always_comb begin
    in_tready     = (state_r == S_IDLE);
    mul_start     = 1'b0;
    cor_ctl.start = 1'b0;
    cor_ctl.mode  = CM_VEC;
    mul_a         = '0;
    mul_b         = '0;
    cor_x0        = t0_r;
    cor_y0        = t1_r;
    cor_z0        = '0;
    case (state_r)
      S_QMUL: begin
        mul_start = issue_r;
        case (mi_r)
          2'd0: begin mul_a = 64'(qx_r); mul_b = 32'(qy_r); end
          2'd1: begin mul_a = 64'(qw_r); mul_b = 32'(qz_r); end
          2'd2: begin mul_a = 64'(qy_r); mul_b = 32'(qy_r); end
          default: begin mul_a = 64'(qz_r); mul_b = 32'(qz_r); end
        endcase
      end
      S_VEC: cor_ctl.start = issue_r && !vec_zero;
      S_GMUL: begin
        mul_start = issue_r;
        case (mi_r)
          2'd0: begin
            mul_a = 64'(px_r) - 64'(cur_x_r); mul_b = 32'($unsigned(gxy_r));
          end
          2'd1: begin
            mul_a = 64'(py_r) - 64'(cur_y_r); mul_b = 32'($unsigned(gxy_r));
          end
          2'd2: begin
            mul_a = 64'(pz_r) - 64'(cur_z_r); mul_b = 32'($unsigned(gz_r));
          end
          default: begin
            mul_a = 64'(th_r) - 64'(cur_h_r); mul_b = 32'($unsigned(gh_r));
          end
        endcase
      end
      S_ROT: begin
        cor_ctl.start = issue_r;
        cor_ctl.mode  = CM_ROT;
        cor_x0        = CORDIC_SCALE;
        cor_y0        = '0;
        cor_z0        = ZW'(cur_h_r) <<< 17;
      end
      S_RMUL: begin
        mul_start = issue_r;
        case (mi_r)
          2'd0: begin mul_a = vx_r; mul_b = c_r; end
          2'd1: begin mul_a = vy_r; mul_b = s_r; end
          2'd2: begin mul_a = vy_r; mul_b = c_r; end
          default: begin mul_a = vx_r; mul_b = s_r; end
        endcase
      end
      default: ;
    endcase
  end

  // rounding helpers on the unit results
  assign sum       = (state_r == S_RMUL && mi_r == 2'd3) ? (acc_r - mul_p) : (acc_r + mul_p);
  assign heading_w = (64'(cor_zo) + 64'sd65536) >>> 17;
  assign cos_w     = (64'(cor_xo) + 64'sd32) >>> 6;
  assign sin_w     = (64'(cor_yo) + 64'sd32) >>> 6;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mi_r        <= '0;
      issue_r     <= 1'b0;
      out_valid_r <= 1'b0;
      gxy_r       <= GAIN_RST;
      gz_r        <= GAIN_RST;
      gh_r        <= GAIN_RST;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      cur_z_r     <= '0;
      cur_h_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_nxt != state_r) begin
        mi_r    <= '0;
        issue_r <= 1'b1;
      end else if (mul_done) begin
        mi_r    <= mi_r + 1'b1;
        issue_r <= 1'b1;
      end else if (mul_start || cor_ctl.start) begin
        issue_r <= 1'b0;
      end
      // result register
      if (state_r == S_EMIT && (!out_valid_r || out_tready)) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      // configuration writes
      if (cfg_we) begin
        case (cfg_index)
          REG_GAIN_XY:      gxy_r <= cfg_wdata;
          REG_GAIN_Z:       gz_r  <= cfg_wdata;
          REG_GAIN_HEADING: gh_r  <= cfg_wdata;
          default: ;
        endcase
      end
      // stored odometry state
      if (accept && in_tuser == ACT_ODOM) begin
        cur_x_r <= in_tdata[31:0];
        cur_y_r <= in_tdata[63:32];
        cur_z_r <= in_tdata[95:64];
      end
      if (state_r == S_VEC) begin
        if (issue_r && vec_zero) cur_h_r <= '0;
        else if (cor_done) cur_h_r <= heading_w[ANG_W-1:0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      px_r <= in_tdata[31:0];
      py_r <= in_tdata[63:32];
      pz_r <= in_tdata[95:64];
      qw_r <= in_tdata[111:96];
      qx_r <= in_tdata[127:112];
      qy_r <= in_tdata[143:128];
      qz_r <= in_tdata[159:144];
      th_r <= in_tdata[175:160];
    end
    if (mul_done) begin
      case (state_r)
        S_QMUL: begin
          case (mi_r)
            2'd1: t1_r <= CW'(sum <<< 1);
            2'd3: t0_r <= CW'(64'sd268435456 - (sum <<< 1));
            default: acc_r <= mul_p;
          endcase
        end
        S_GMUL: begin
          case (mi_r)
            2'd0: vx_r <= (mul_p + 64'sd2048) >>> 12;
            2'd1: vy_r <= (mul_p + 64'sd2048) >>> 12;
            2'd2: oz_r <= sat32((mul_p + 64'sd2048) >>> 12);
            default: oh_r <= sat32((mul_p + 64'sd256) >>> 9);
          endcase
        end
        S_RMUL: begin
          case (mi_r)
            2'd1: ox_r <= sat32((sum + 64'sd8388608) >>> 24);
            2'd3: oy_r <= sat32((sum + 64'sd8388608) >>> 24);
            default: acc_r <= mul_p;
          endcase
        end
        default: ;
      endcase
    end
    if (state_r == S_ROT && cor_done) begin
      c_r <= cos_w[31:0];
      s_r <= sin_w[31:0];
    end
    if (state_r == S_EMIT && (!out_valid_r || out_tready)) begin
      out_data_r <= {oh_r, oz_r, oy_r, ox_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  bfpc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .done  (mul_done),
    .p_o   (mul_p)
  );

  bfpc_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (cor_ctl),
    .x_i   (cor_x0),
    .y_i   (cor_y0),
    .z_i   (cor_z0),
    .done  (cor_done),
    .x_o   (cor_xo),
    .y_o   (cor_yo),
    .z_o   (cor_zo)
  );

endmodule

[tb/testbench.sv]
// Self-checking testbench for the body-frame proportional position controller.
`timescale 1ns / 1ps
module testbench;
  import bfpc_pkg::*;

  localparam int  STEPS     = 16;
  localparam int  WD_LIMIT  = 20000;
  localparam int  IDLE_WAIT = 400;

  typedef struct {
    logic               act;
    logic signed [31:0] px, py, pz;
    logic signed [15:0] qw, qx, qy, qz, th;
  } pose_item_t;

  typedef struct {
    logic signed [31:0] vx, vy, vz, hr;
  } vel_cmd_t;

  typedef enum int {PH_NONE, PH_SEND, PH_RECV, PH_BOTH} idle_phase_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [GAIN_W-1:0] cfg_wdata = '0;

  // predictor state
  logic [15:0] m_gxy, m_gz, m_gh;
  logic signed [31:0] m_x, m_y, m_z;
  logic signed [15:0] m_hd;

  vel_cmd_t    cmd_q[$];
  int          n_err = 0;
  int          wd = 0;
  idle_phase_t phase = PH_NONE;

  always #4 clk = ~clk;

  body_frame_position_p_controller_top i_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .cfg_we, .cfg_index, .cfg_wdata
  );

  function automatic longint atan_tab(int i);
    longint t[24] = '{843314857, 497837829, 263043837, 133525158, 67021687,
                      33543516, 16775851, 8388437, 4194283, 2097149, 1048576,
                      524288, 262144, 131072, 65536, 32768, 16384, 8192, 4096,
                      2048, 1024, 512, 256, 128};
    return t[i];
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // CORDIC vectoring: heading of (x, y) in Q3.13
  function automatic logic signed [15:0] heading_of(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      z = (y >= 0) ? 64'sd3373259426 : -64'sd3373259426;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_tab(i);
      end else begin
        x -= dx; y += dy; z -= atan_tab(i);
      end
    end
    return 16'((z + 65536) >>> 17);
  endfunction

  // CORDIC rotation: cos and sin in Q1.24
  task automatic cos_sin_of(input logic signed [15:0] ang, output longint c,
                            output longint s);
    longint z, x, y, dx, dy;
    bit neg;
    z = longint'(ang) * 131072;
    x = 652032874;
    y = 0;
    neg = 0;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426; neg = 1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426; neg = 1;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab(i);
      end else begin
        x += dx; y -= dy; z += atan_tab(i);
      end
    end
    if (neg) begin
      x = -x; y = -y;
    end
    c = (x + 32) >>> 6;
    s = (y + 32) >>> 6;
  endtask

  // update pose or queue the velocity command a target causes
  task automatic predict_command(input pose_item_t it);
    longint t1, t0, ex, ey, c, s;
    vel_cmd_t r;
    if (it.act == ACT_ODOM) begin
      t1 = 2 * (longint'(it.qx) * it.qy + longint'(it.qw) * it.qz);
      t0 = (64'sd1 << 28) - 2 * (longint'(it.qy) * it.qy + longint'(it.qz) * it.qz);
      m_x = it.px; m_y = it.py; m_z = it.pz;
      m_hd = heading_of(t1, t0);
    end else begin
      ex = (longint'(m_gxy) * (longint'(it.px) - m_x) + 2048) >>> 12;
      ey = (longint'(m_gxy) * (longint'(it.py) - m_y) + 2048) >>> 12;
      cos_sin_of(m_hd, c, s);
      r.vx = 32'(clamp32((c * ex + s * ey + 8388608) >>> 24));
      r.vy = 32'(clamp32((c * ey - s * ex + 8388608) >>> 24));
      r.vz = 32'(clamp32((longint'(m_gz) * (longint'(it.pz) - m_z) + 2048) >>> 12));
      r.hr = 32'(clamp32((longint'(m_gh) * (longint'(it.th) - m_hd) + 256) >>> 9));
      cmd_q.push_back(r);
    end
  endtask

  function automatic bit roll_idle(int pct_on);
    return $urandom_range(99) < pct_on;
  endfunction

  // send one item, with sender gaps per phase; valid stays up until a gap or a pause
  task automatic send_item(input pose_item_t it);
    while ((phase == PH_SEND && roll_idle(56)) || (phase == PH_BOTH && roll_idle(11))) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.act;
    in_tdata  <= {it.th, it.qz, it.qy, it.qx, it.qw, it.pz, it.py, it.px};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_command(it);
  endtask

  // receiver stalls and result check
  always @(posedge clk) begin
    vel_cmd_t e, a;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        a.vx = out_tdata[31:0];   a.vy = out_tdata[63:32];
        a.vz = out_tdata[95:64];  a.hr = out_tdata[127:96];
        if (cmd_q.size() == 0) begin
          $display("%0t: unexpected command %h", $time, out_tdata);
          n_err++;
        end else begin
          e = cmd_q.pop_front();
          if (e.vx !== a.vx) begin
            $display("%0t: vel_x exp %0d got %0d", $time, e.vx, a.vx); n_err++;
          end
          if (e.vy !== a.vy) begin
            $display("%0t: vel_y exp %0d got %0d", $time, e.vy, a.vy); n_err++;
          end
          if (e.vz !== a.vz) begin
            $display("%0t: vel_z exp %0d got %0d", $time, e.vz, a.vz); n_err++;
          end
          if (e.hr !== a.hr) begin
            $display("%0t: heading_rate exp %0d got %0d", $time, e.hr, a.hr); n_err++;
          end
        end
      end
      case (phase)
        PH_RECV: out_tready <= !roll_idle(56);
        PH_BOTH: out_tready <= !roll_idle(11);
        default: out_tready <= 1'b1;
      endcase
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) wd <= 0;
    else wd <= wd + 1;
    if (wd >= WD_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_gain(input logic [1:0] idx, input logic [15:0] v);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= v;
    @(posedge clk);
    if (idx == REG_GAIN_XY) m_gxy = v;
    else if (idx == REG_GAIN_Z) m_gz = v;
    else m_gh = v;
  endtask

  // drain outstanding commands, then let an odometry item finish
  task automatic settle();
    in_tvalid <= 1'b0;
    while (cmd_q.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  task automatic set_gains(input logic [15:0] gxy, gz, gh);
    settle();
    write_gain(REG_GAIN_XY, gxy);
    write_gain(REG_GAIN_Z, gz);
    write_gain(REG_GAIN_HEADING, gh);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [15:0] rand_quat();
    case ($urandom_range(3))
      0: return 16'sd16384;
      1: return -16'sd16384;
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_pos();
    case ($urandom_range(5))
      0: return 32'($urandom);
      1: return 32'sh7FFF_FFFF;
      2: return 32'sh8000_0000;
      default: return 32'($signed($urandom_range(2000000)) - 1000000);
    endcase
  endfunction

  function automatic pose_item_t rand_item(logic act);
    pose_item_t it;
    it.act = act;
    it.px = rand_pos(); it.py = rand_pos(); it.pz = rand_pos();
    it.qw = rand_quat(); it.qx = rand_quat(); it.qy = rand_quat(); it.qz = rand_quat();
    // occasional raw words outside the nominal ranges
    if ($urandom_range(15) == 0) begin
      it.qw = 16'($urandom); it.qz = 16'($urandom);
    end
    it.th = ($urandom_range(7) == 0) ? 16'($urandom)
                                       : 16'($signed($urandom_range(51472)) - 25736);
    return it;
  endfunction

  function automatic pose_item_t mk(logic act, logic signed [31:0] x, y, z,
                                    logic signed [15:0] w, qx, qy, qz, th);
    pose_item_t it;
    it.act = act; it.px = x; it.py = y; it.pz = z;
    it.qw = w; it.qx = qx; it.qy = qy; it.qz = qz; it.th = th;
    return it;
  endfunction

  // edge cases: zero quaternion, turned vector, half-turn headings, saturation
  task automatic test_directed();
    send_item(mk(ACT_TARGET, 32'sh10000, -32'sh10000, 32'sh20000, 0, 0, 0, 0, 16'sd25736));
    send_item(mk(ACT_ODOM, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(ACT_TARGET, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 0, 0,
                 -16'sd25736));
    send_item(mk(ACT_ODOM, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                 0, 0, 0, 16'sd16384, 0));
    send_item(mk(ACT_TARGET, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 0, 0,
                 16'sh7FFF));
    send_item(mk(ACT_ODOM, 32'sh1234_5678, -32'sh0123_4567, 0, 0, 0, 0, -16'sd16384, 0));
    send_item(mk(ACT_TARGET, 0, 0, 0, 0, 0, 0, 0, 16'sh8000));
    send_item(mk(ACT_ODOM, 0, 0, 0, 16'sd11585, 0, 0, 16'sd11585, 0));
    send_item(mk(ACT_TARGET, 32'sh30000, 32'sh50000, -32'sh40000, 0, 0, 0, 0, 0));
    send_item(mk(ACT_ODOM, 0, 0, 0, 16'sd11585, 0, 0, -16'sd11585, 0));
    send_item(mk(ACT_TARGET, 32'sh30000, 32'sh50000, -32'sh40000, 0, 0, 0, 0, 0));
    send_item(mk(ACT_ODOM, 1, -1, 1, -16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384, 0));
    send_item(mk(ACT_TARGET, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 0, 0,
                 16'sd25736));
    send_item(mk(ACT_ODOM, 0, 0, 0, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 0));
    send_item(mk(ACT_TARGET, -32'sd1, 32'sd1, -32'sd1, 0, 0, 0, 0, 16'sd1));
  endtask

  // random traffic, mostly targets mixed with odometry
  task automatic test_random(int n);
    for (int i = 0; i < n; i++)
      send_item(rand_item(($urandom_range(99) < 60) ? ACT_TARGET : ACT_ODOM));
  endtask

  initial begin
    m_gxy = GAIN_RST; m_gz = GAIN_RST; m_gh = GAIN_RST;
    m_x = '0; m_y = '0; m_z = '0; m_hd = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF);
    test_directed();
    set_gains(16'h0000, 16'h0000, 16'h0000);
    phase = PH_SEND;
    test_random(100);
    set_gains(16'h1000, 16'h8000, 16'h0001);
    test_random(200);
    phase = PH_RECV;
    set_gains(16'($urandom), 16'($urandom), 16'($urandom));
    test_random(200);
    phase = PH_BOTH;
    set_gains(16'd819, 16'hFFFF, 16'h4000);
    test_random(200);
    phase = PH_NONE;
    test_random(100);

    settle();
    if (n_err == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

[body_frame_position_p_controller_top.f]
rtl/bfpc_pkg.sv
rtl/bfpc_mul.sv
rtl/bfpc_cordic.sv
rtl/body_frame_position_p_controller_top.sv
tb/testbench.sv
